FILE: src/bfsp_pkg.sv
// Shared types, constants and codes of the best-fit shelf packer.
package bfsp_pkg;

  localparam int unsigned CoordW             = 15;
  localparam int unsigned OriginW            = 14;
  localparam int unsigned AreaW              = 2 * CoordW;
  localparam int unsigned CfgIdxW            = 3;
  localparam int unsigned MaxShelvesDefault  = 64;
  localparam logic [CoordW-1:0] CoordMax     = {CoordW{1'b1}};

  typedef enum logic [2:0] {
    STAT_PLACED   = 3'd0,
    STAT_REJECTED = 3'd1,
    STAT_ABORTED  = 3'd2,
    STAT_SKIPPED  = 3'd3,
    STAT_OK       = 3'd4,
    STAT_FAILED   = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_ATLAS_WIDTH  = 3'd2,
    CFG_ATLAS_HEIGHT = 3'd3,
    CFG_STRICT_MODE  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_DELIVER
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] item_width;
    logic [CoordW-1:0] item_height;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [2:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [CoordW-1:0] cursor;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] height;
  } shelf_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic decide;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_end;
    logic aborted;
    logic count_zero;
    logic last_idx;
    logic pipe_busy;
  } dpath_stat_t;

endpackage

FILE: src/best_fit_shelf_packer_unit.sv
// Top level of the best-fit shelf packer: controller and datapath joined by command and status.
//
// This block places rectangles, sorted upstream by falling height, on horizontal shelves of an
// atlas. Each rectangle request goes to the open shelf with the smallest remaining area that
// still holds it, the earliest shelf winning a tie; otherwise a new shelf as tall as the
// rectangle opens below the used area if it fits, else the rectangle is rejected or, in strict
// mode, aborts the batch. An end-of-batch request reports whether the batch held together and
// clears all shelves. Every request yields exactly one result request. The block works on one
// request at a time. With N open shelves (at most MaxShelves), a rectangle passes through the
// check, the scan of all N shelves, the pipeline drain, the decision and the hand-over to the
// output register, and only then is the next request taken. The shelf table sits in a memory
// with one read port and one write port that is read one shelf per cycle during the scan, and
// the fit test and area multiply follow in a short pipeline. End-of-batch requests, requests
// after an abort and rectangles arriving with no open shelf skip the scan and go from the check
// straight to the decision. A finished result sits in an output register, so the next request
// is accepted while it still waits to be taken; a later result waits at the hand-over for the
// register to empty or be taken.
// Configuration writes are always accepted and must only arrive while the block is idle.
module best_fit_shelf_packer_unit #(
  parameter int unsigned MaxShelves = bfsp_pkg::MaxShelvesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bfsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bfsp_pkg::CoordW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bfsp_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bfsp_pkg::out_item_t          out_data_o
);
  import bfsp_pkg::*;

  ctrl_cmd_t   cmd;
  dpath_stat_t stat;

  // Registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  bfsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfsp_dpath #(
    .MaxShelves (MaxShelves)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

FILE: src/bfsp_ctrl.sv
// Controller state machine of the shelf packer: sequences accept, scan, decision and delivery.
module bfsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bfsp_pkg::dpath_stat_t stat_i,
  output bfsp_pkg::ctrl_cmd_t  cmd_o
);
  import bfsp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.is_end || stat_i.aborted || stat_i.count_zero) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.last_idx) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
      end
      ST_DELIVER: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/bfsp_dpath.sv
// Datapath of the shelf packer: configuration, shelf memory, scan pipeline and result registers.
module bfsp_dpath #(
  parameter int unsigned MaxShelves = bfsp_pkg::MaxShelvesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [bfsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bfsp_pkg::CoordW-1:0] cfg_data_i,
  input  bfsp_pkg::in_item_t          in_data_i,
  output bfsp_pkg::out_item_t         out_data_o,
  input  bfsp_pkg::ctrl_cmd_t         cmd_i,
  output bfsp_pkg::dpath_stat_t       stat_o
);
  import bfsp_pkg::*;

  localparam int unsigned IdxW = (MaxShelves > 1) ? $clog2(MaxShelves) : 1;
  localparam int unsigned CntW = $clog2(MaxShelves + 1);

  // Configuration registers.
  logic [OriginW-1:0] origin_x_q, origin_y_q;
  logic [CoordW-1:0]  atlas_w_q, atlas_h_q;
  logic               strict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      atlas_w_q  <= CoordW'(1024);
      atlas_h_q  <= CoordW'(1024);
      strict_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:     origin_x_q <= cfg_data_i[OriginW-1:0];
        CFG_ORIGIN_Y:     origin_y_q <= cfg_data_i[OriginW-1:0];
        CFG_ATLAS_WIDTH:  atlas_w_q  <= cfg_data_i;
        CFG_ATLAS_HEIGHT: atlas_h_q  <= cfg_data_i;
        CFG_STRICT_MODE:  strict_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Item under work.
  in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  // Right edge of the atlas, saturated to the coordinate range.
  logic [CoordW:0]   edge_sum;
  logic [CoordW-1:0] right_edge;
  assign edge_sum   = {2'b00, origin_x_q} + {1'b0, atlas_w_q};
  assign right_edge = edge_sum[CoordW] ? CoordMax : edge_sum[CoordW-1:0];

  // Batch state.
  logic [CntW-1:0]   count_q, count_d;
  logic [CoordW-1:0] used_q, used_d;
  logic              aborted_q, aborted_d;

  // Shelf memory, one read port for the scan and one write port for updates.
  shelf_t            shelf_mem [MaxShelves];
  shelf_t            rd_data_q;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  shelf_t            wr_data;
  logic [IdxW-1:0]   rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) shelf_mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= shelf_mem[rd_idx_q];
  end

  // Scan pipeline: read, then remaining width, fit test and area, then best-so-far.
  logic              s1_valid_q, s2_valid_q;
  logic [IdxW-1:0]   s1_idx_q, s2_idx_q;
  logic              s2_fit_q;
  logic [AreaW-1:0]  s2_area_q;
  shelf_t            s2_entry_q;

  logic [CoordW-1:0] s1_rem;
  logic              s1_fit;
  assign s1_rem = (rd_data_q.cursor >= right_edge) ? '0 : right_edge - rd_data_q.cursor;
  assign s1_fit = (item_q.item_height <= rd_data_q.height) && (item_q.item_width <= s1_rem);

  logic              found_q;
  logic [AreaW-1:0]  best_area_q;
  shelf_t            best_entry_q;
  logic [IdxW-1:0]   best_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.rd_en;
      s2_valid_q <= s1_valid_q;
      if (cmd_i.load) begin
        rd_idx_q <= '0;
        found_q  <= 1'b0;
      end else begin
        if (cmd_i.rd_en) rd_idx_q <= rd_idx_q + IdxW'(1);
        if (s2_valid_q && s2_fit_q && (!found_q || s2_area_q < best_area_q)) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= rd_idx_q;
    if (s1_valid_q) begin
      s2_idx_q   <= s1_idx_q;
      s2_fit_q   <= s1_fit;
      s2_area_q  <= s1_rem * rd_data_q.height;
      s2_entry_q <= rd_data_q;
    end
    // The earliest shelf keeps a tie because only a strictly smaller area replaces it.
    if (s2_valid_q && s2_fit_q && (!found_q || s2_area_q < best_area_q)) begin
      best_area_q  <= s2_area_q;
      best_entry_q <= s2_entry_q;
      best_idx_q   <= s2_idx_q;
    end
  end

  // Decision on the scanned item.
  logic [CoordW-1:0] rem_h;
  logic              new_ok;
  logic [CoordW-1:0] new_top;
  out_item_t         res_d, res_q, out_q;
  logic [CoordW:0]   top_sum, cur_sum, used_sum, best_sum;

  assign rem_h    = (used_q >= atlas_h_q) ? '0 : atlas_h_q - used_q;
  assign new_ok   = (item_q.item_width <= atlas_w_q) && (item_q.item_height <= rem_h)
                    && (count_q < CntW'(MaxShelves));
  assign top_sum  = {2'b00, origin_y_q} + {1'b0, used_q};
  assign new_top  = top_sum[CoordW-1:0];
  assign cur_sum  = {2'b00, origin_x_q} + {1'b0, item_q.item_width};
  assign used_sum = {1'b0, used_q} + {1'b0, item_q.item_height};
  assign best_sum = {1'b0, best_entry_q.cursor} + {1'b0, item_q.item_width};

  always_comb begin
    res_d     = '0;
    count_d   = count_q;
    used_d    = used_q;
    aborted_d = aborted_q;
    wr_en     = 1'b0;
    wr_addr   = best_idx_q;
    wr_data   = best_entry_q;
    if (item_q.kind) begin
      res_d.status = aborted_q ? STAT_FAILED : STAT_OK;
      count_d      = '0;
      used_d       = '0;
      aborted_d    = 1'b0;
    end else if (aborted_q) begin
      res_d.status = STAT_SKIPPED;
    end else if (found_q) begin
      res_d.pos_x    = best_entry_q.cursor;
      res_d.pos_y    = best_entry_q.top;
      res_d.status   = STAT_PLACED;
      wr_en          = 1'b1;
      wr_data.cursor = best_sum[CoordW-1:0];
    end else if (new_ok) begin
      res_d.pos_x    = CoordW'(origin_x_q);
      res_d.pos_y    = new_top;
      res_d.status   = STAT_PLACED;
      wr_en          = 1'b1;
      wr_addr        = count_q[IdxW-1:0];
      wr_data.cursor = cur_sum[CoordW-1:0];
      wr_data.top    = new_top;
      wr_data.height = item_q.item_height;
      count_d        = count_q + CntW'(1);
      used_d         = used_sum[CoordW-1:0];
    end else if (strict_q) begin
      res_d.status = STAT_ABORTED;
      count_d      = '0;
      used_d       = '0;
      aborted_d    = 1'b1;
    end else begin
      res_d.status = STAT_REJECTED;
    end
    if (!cmd_i.decide) wr_en = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      used_q    <= '0;
      aborted_q <= 1'b0;
    end else if (cmd_i.decide) begin
      count_q   <= count_d;
      used_q    <= used_d;
      aborted_q <= aborted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) res_q <= res_d;
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_data_o = out_q;

  assign stat_o.is_end     = item_q.kind;
  assign stat_o.aborted    = aborted_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.last_idx   = (CntW'(rd_idx_q) == count_q - CntW'(1));
  assign stat_o.pipe_busy  = s1_valid_q || s2_valid_q;

endmodule

FILE: src/bfsp_checker.sv
// Port-level checker for the shelf packer, bound to the top level.
module bfsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [bfsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [bfsp_pkg::CoordW-1:0]  cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input bfsp_pkg::in_item_t           in_data_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input bfsp_pkg::out_item_t          out_data_o
);
  import bfsp_pkg::*;

  // A result that is not taken holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only a placed rectangle carries a position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_PLACED |->
      out_data_o.pos_x == '0 && out_data_o.pos_y == '0)
    else $error("position on an unplaced result");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= STAT_FAILED)
    else $error("undefined status code");

  // One request is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request accepted while busy");

endmodule

bind best_fit_shelf_packer_unit bfsp_checker u_bfsp_checker (.*);

FILE: sim/tb_best_fit_shelf_packer_unit.sv
// Self-checking testbench of the best-fit shelf packer: directed cases, random batches, then back-pressure.
module tb_best_fit_shelf_packer_unit;
  import bfsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ShelfSlots = MaxShelvesDefault;
  localparam int          CycleLimit = 1000000;
  localparam int          HoldCycles = 500;
  localparam int          TailCycles = ShelfSlots + 16;

  logic                clk_i;
  logic                rst_n     = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_e            cfg_index = CFG_ORIGIN_X;
  logic [CoordW-1:0]   cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;

  best_fit_shelf_packer_unit #(
    .MaxShelves(ShelfSlots)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Predicted register copies and shelf table, written only by the monitor below.
  logic [OriginW-1:0] org_x  = '0;
  logic [OriginW-1:0] org_y  = '0;
  logic [CoordW-1:0]  atl_w  = 15'd1024;
  logic [CoordW-1:0]  atl_h  = 15'd1024;
  logic               strict = 1'b1;
  logic [CoordW-1:0]  shelf_cur   [ShelfSlots];
  logic [CoordW-1:0]  shelf_top_y [ShelfSlots];
  logic [CoordW-1:0]  shelf_ht    [ShelfSlots];
  int unsigned        n_shelves     = 0;
  logic [CoordW-1:0]  used_h        = '0;
  logic               batch_aborted = 1'b0;

  out_item_t placements_due[$];
  int        errors  = 0;
  int        cycles  = 0;

  // Idle rates in percent of cycles; the receiver rate is only changed by NBA.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // A new stall order makes the receiver hold off, counting down from HoldCycles.
  int stall_order = 0;
  int stall_seen  = 0;
  int stall_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random idling, plus long hold-offs on request from the test sequence.
  always @(posedge clk_i) begin
    if (stall_order != stall_seen) begin
      stall_seen <= stall_order;
      stall_left <= HoldCycles;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Works out the result of one rectangle or end-of-batch request and updates the shelf table.
  function automatic out_item_t place_request(input in_item_t req);
    out_item_t       res;
    logic [15:0]     edge_sum;
    logic [CoordW-1:0] right_x, room, room_h;
    longint unsigned area, best_area;
    int              best, i;
    bit              found;
    res = '0;
    if (req.kind) begin
      // End of batch: report and start over with an empty atlas.
      res.status    = batch_aborted ? STAT_FAILED : STAT_OK;
      n_shelves     = 0;
      used_h        = '0;
      batch_aborted = 1'b0;
    end else if (batch_aborted) begin
      res.status = STAT_SKIPPED;
    end else begin
      edge_sum = {2'b00, org_x} + {1'b0, atl_w};
      right_x  = (edge_sum > {1'b0, CoordMax}) ? CoordMax : edge_sum[CoordW-1:0];
      found     = 1'b0;
      best      = 0;
      best_area = 0;
      for (i = 0; i < n_shelves; i++) begin
        room = (shelf_cur[i] >= right_x) ? '0 : right_x - shelf_cur[i];
        if (req.item_height <= shelf_ht[i] && req.item_width <= room) begin
          area = longint'(room) * longint'(shelf_ht[i]);
          // Strictly smaller only, so the earliest shelf keeps a tie.
          if (!found || area < best_area) begin
            found     = 1'b1;
            best      = i;
            best_area = area;
          end
        end
      end
      if (found) begin
        res.pos_x       = shelf_cur[best];
        res.pos_y       = shelf_top_y[best];
        shelf_cur[best] = shelf_cur[best] + req.item_width;
        res.status      = STAT_PLACED;
      end else begin
        room_h = (used_h >= atl_h) ? '0 : atl_h - used_h;
        if (req.item_width <= atl_w && req.item_height <= room_h &&
            n_shelves < ShelfSlots) begin
          res.pos_x              = {1'b0, org_x};
          res.pos_y              = {1'b0, org_y} + used_h;
          shelf_top_y[n_shelves] = res.pos_y;
          shelf_ht[n_shelves]    = req.item_height;
          shelf_cur[n_shelves]   = {1'b0, org_x} + req.item_width;
          n_shelves              = n_shelves + 1;
          used_h                 = used_h + req.item_height;
          res.status             = STAT_PLACED;
        end else if (strict) begin
          n_shelves     = 0;
          used_h        = '0;
          batch_aborted = 1'b1;
          res.status    = STAT_ABORTED;
        end else begin
          res.status = STAT_REJECTED;
        end
      end
    end
    return res;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
  endtask

  // Monitor: tracks register writes and accepted requests, and checks every result.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t due;
    if (rst_n) begin
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_ORIGIN_X:     org_x  = cfg_data[OriginW-1:0];
          CFG_ORIGIN_Y:     org_y  = cfg_data[OriginW-1:0];
          CFG_ATLAS_WIDTH:  atl_w  = cfg_data;
          CFG_ATLAS_HEIGHT: atl_h  = cfg_data;
          CFG_STRICT_MODE:  strict = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (placements_due.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, expected none, got status %0d",
                   $time, out_data.status);
        end else begin
          want = placements_due.pop_front();
          if (out_data.pos_x !== want.pos_x)   report_field("pos_x", want.pos_x, out_data.pos_x);
          if (out_data.pos_y !== want.pos_y)   report_field("pos_y", want.pos_y, out_data.pos_y);
          if (out_data.status !== want.status) report_field("status", want.status, out_data.status);
        end
      end
      if (in_valid && in_ready === 1'b1) begin
        due = place_request(in_data);
        placements_due.insert(placements_due.size(), due);
      end
    end
  end

  // Offers one request, idling first at the current sender rate, and waits for acceptance.
  // Valid is left high so that back-to-back requests never lower and raise it in one step.
  task automatic send_request(input logic kind, input int w, input int h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid          <= 1'b1;
    in_data.kind        <= kind;
    in_data.item_width  <= w[CoordW-1:0];
    in_data.item_height <= h[CoordW-1:0];
    do @(posedge clk_i); while (in_ready !== 1'b1);
  endtask

  // The sender pauses until every result of the requests sent so far has been taken.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk_i); while (placements_due.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CoordW-1:0];
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
  endtask

  // Writes every register; only called with the block idle.
  task automatic configure(input int ox, input int oy, input int aw, input int ah, input int sm);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ATLAS_WIDTH, aw);
    write_reg(CFG_ATLAS_HEIGHT, ah);
    write_reg(CFG_STRICT_MODE, sm);
    cfg_valid <= 1'b0;
  endtask

  // New shelves, placement on an open shelf, best fit over order, tie to the earliest shelf.
  task automatic test_basic_placement;
    configure(0, 0, 1024, 1024, 1);
    send_request(1'b0, 100, 50);
    send_request(1'b0, 200, 40);
    send_request(1'b0, 1024, 30);
    send_request(1'b0, 0, 0);      // full shelf has zero area left, so it wins
    send_request(1'b1, 0, 0);
    send_request(1'b0, 524, 20);
    send_request(1'b0, 524, 20);   // two shelves with equal remaining area now
    send_request(1'b0, 10, 10);
    send_request(1'b1, 16384, 16384);
    drain();
  endtask

  // A misfit in strict mode aborts, later rectangles are skipped, the batch fails.
  task automatic test_strict_abort;
    configure(0, 0, 64, 1, 1);
    send_request(1'b0, 64, 1);
    send_request(1'b0, 65, 1);
    send_request(1'b0, 1, 1);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 0, 0);
    send_request(1'b0, 3, 1);
    send_request(1'b1, 0, 0);
    drain();
  endtask

  // In lenient mode misfits are rejected and the batch still succeeds; one-pixel atlas width.
  task automatic test_lenient_reject;
    configure(5, 7, 1, 40, 0);
    send_request(1'b0, 1, 40);
    send_request(1'b0, 0, 0);
    send_request(1'b0, 1, 1);
    send_request(1'b0, 2, 0);
    send_request(1'b1, 0, 0);
    drain();
  endtask

  // Largest origin, atlas and rectangle of 16384 by 16384, zero-height shelf at the bottom edge.
  task automatic test_extremes;
    configure(16383, 16383, 16384, 16384, 1);
    send_request(1'b0, 16384, 16384);
    send_request(1'b0, 0, 0);
    send_request(1'b0, 1, 0);
    send_request(1'b0, 1, 1);
    send_request(1'b1, 16384, 16384);
    drain();
  endtask

  // Registers changed in mid-batch leave a cursor past the right edge and no height left.
  task automatic test_midbatch_config;
    configure(0, 0, 1024, 1024, 0);
    send_request(1'b0, 600, 100);
    drain();
    configure(0, 0, 500, 1024, 0);
    send_request(1'b0, 0, 50);
    drain();
    configure(0, 0, 500, 50, 0);
    send_request(1'b0, 10, 0);
    send_request(1'b0, 10, 1);
    send_request(1'b1, 0, 0);
    drain();
  endtask

  // Every shelf in use: the next new shelf is a misfit, in strict and in lenient mode.
  task automatic test_full_table;
    int k;
    configure(0, 0, 8, 1024, 1);
    for (k = 0; k <= ShelfSlots; k++) send_request(1'b0, 8, 1);
    send_request(1'b1, 0, 0);
    drain();
    configure(0, 0, 8, 1024, 0);
    for (k = 0; k <= ShelfSlots + 1; k++) send_request(1'b0, 8, k % 2);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 0, 0);
    drain();
  endtask

  // The receiver holds off long while the sender keeps offering, so the block fills and stalls.
  task automatic test_backpressure;
    int k;
    configure(0, 0, 256, 256, 0);
    stall_order <= stall_order + 1;
    for (k = 0; k < 40; k++) begin
      if (k % 12 == 11) send_request(1'b1, 0, 0);
      else send_request(1'b0, $urandom_range(0, 90), 40 - k);
    end
    send_request(1'b1, 0, 0);
    drain();
  endtask

  // Random batches of height-sorted rectangles with random settings, plus some noise.
  task automatic test_random_batches(input int n_items, input int s_idle, input int r_idle);
    int sent, len, k, w, h, aw, ah, pick;
    bit fill;
    sent          = 0;
    send_idle_pct = s_idle;
    recv_idle_pct <= r_idle;
    aw            = 0;
    ah            = 0;
    while (sent < n_items) begin
      if (aw == 0 || $urandom_range(3) == 0) begin
        drain();
        case ($urandom_range(4))
          0:       aw = 1;
          1:       aw = 16384;
          2:       aw = $urandom_range(1, 16384);
          default: aw = $urandom_range(16, 600);
        endcase
        case ($urandom_range(4))
          0:       ah = 1;
          1:       ah = 16384;
          2:       ah = $urandom_range(1, 16384);
          default: ah = $urandom_range(16, 600);
        endcase
        pick = $urandom_range(2);
        configure(pick == 0 ? 0 : pick == 1 ? 16383 : $urandom_range(0, 16383),
                  $urandom_range(1) ? 0 : $urandom_range(0, 16383),
                  aw, ah, $urandom_range(1));
      end
      // Now and then a batch of flat full-width rectangles runs the shelf table full.
      fill = ($urandom_range(15) == 0);
      len  = fill ? ShelfSlots + $urandom_range(1, 3) : $urandom_range(1, 24);
      h    = $urandom_range(0, ah / 2);
      for (k = 0; k < len; k++) begin
        if (fill) begin
          send_request(1'b0, aw, $urandom_range(0, 1));
        end else if ($urandom_range(19) == 0) begin
          send_request($urandom_range(1), $urandom_range(0, 16384), $urandom_range(0, 16384));
        end else begin
          h = h - $urandom_range(0, h / 4);
          w = ($urandom_range(3) == 0) ? $urandom_range(0, aw) : $urandom_range(0, aw / 4 + 1);
          send_request(1'b0, w, h);
        end
      end
      send_request(1'b1, $urandom_range(0, 16384), $urandom_range(0, 16384));
      sent = sent + len + 1;
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Sender idles less than the receiver through the directed cases and the first random part.
    send_idle_pct = 26;
    recv_idle_pct <= 68;
    test_basic_placement();
    test_strict_abort();
    test_lenient_reject();
    test_extremes();
    test_midbatch_config();
    test_full_table();
    test_random_batches(300, 26, 68);
    test_random_batches(300, 68, 26);
    test_random_batches(300, 0, 0);
    test_backpressure();

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
